[design/sfpa_pkg.sv]
// ----------------------------------------------------------------------------
// sfpa_pkg: shared types and constants
// Register codes, fixed-point constants and payload structs for the
// scattering factor phase accumulator.
// ----------------------------------------------------------------------------
package sfpa_pkg;

  localparam int TERM_COUNT = 3;
  localparam int IDX_W      = (TERM_COUNT > 1) ? $clog2(TERM_COUNT) : 1;

  localparam logic [2:0] CFG_WAVELENGTH   = 3'd0;
  localparam logic [2:0] CFG_MASS_RATIO   = 3'd1;
  localparam logic [2:0] CFG_INVERSE_AREA = 3'd2;
  localparam logic [2:0] CFG_LORENTZ_NUM  = 3'd3;
  localparam logic [2:0] CFG_LORENTZ_OFS  = 3'd4;
  localparam logic [2:0] CFG_GAUSS_WEIGHT = 3'd5;
  localparam logic [2:0] CFG_GAUSS_RATE   = 3'd6;

  localparam logic [35:0] F_MAX        = 36'hF_FFFF_FFFF;
  localparam logic [30:0] Q30_ONE      = 31'h4000_0000;
  localparam logic [31:0] EXP_NEG_ONE  = 32'd395007542;
  localparam logic [31:0] HALF_PI      = 32'd1686629713;
  localparam logic [3:0]  EXP_TERMS    = 4'd12;
  localparam logic [3:0]  TRIG_TERMS   = 4'd14;

  typedef struct packed {
    logic [15:0] wavelength;
    logic [15:0] mass_ratio;
    logic [23:0] inverse_area;
    logic [47:0] lorentz_numerators;
    logic [47:0] lorentz_offsets;
    logic [47:0] gauss_weights;
    logic [47:0] gauss_rates;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] freq_x;
    logic signed [15:0] freq_y;
    logic signed [19:0] pos_x;
    logic signed [19:0] pos_y;
    logic               clear_sum;
  } item_t;

  // one 16-bit coefficient of a packed register, zero past the third term
  function automatic logic [15:0] coef(input logic [47:0] packed_reg,
                                       input logic [IDX_W-1:0] idx);
    logic [15:0] val;
    val = 16'd0;
    for (int i = 0; i < 3; i++) begin
      if (32'(idx) == i) val = packed_reg[16*i +: 16];
    end
    return val;
  endfunction

endpackage

[design/sfpa_mul.sv]
// ----------------------------------------------------------------------------
// sfpa_mul: shared multiplier
// 40 x 32 bit unsigned product summed from two 20 x 32 partial products.
// ----------------------------------------------------------------------------
module sfpa_mul (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [39:0] a,
  input  logic [31:0] b,
  output logic        done,
  output logic [71:0] prod
);
  logic        busy;
  logic [19:0] a_hi;
  logic [31:0] b_r;
  logic [51:0] lo_prod;
  logic [51:0] hi_prod;

  assign lo_prod = 52'(a[19:0]) * 52'(b);
  assign hi_prod = 52'(a_hi) * 52'(b_r);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod <= 72'(lo_prod);
      a_hi <= a[39:20];
      b_r  <= b;
    end else if (busy) begin
      prod <= prod + {hi_prod, 20'd0};
    end
  end
endmodule

[design/sfpa_div.sv]
// ----------------------------------------------------------------------------
// sfpa_div: shared divider
// Restoring radix-2 divider, one quotient bit per cycle, 54 or 32 bits.
// ----------------------------------------------------------------------------
module sfpa_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        wide,
  input  logic [53:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [53:0] quot
);
  localparam logic [5:0] WIDE_STEPS   = 6'd54;
  localparam logic [5:0] NARROW_STEPS = 6'd32;

  logic        busy;
  logic [5:0]  cnt;
  logic [31:0] rem;
  logic [31:0] dvs;
  logic [32:0] rem_s;
  logic [32:0] diff;
  logic        ge;

  assign rem_s = {rem, quot[53]};
  assign diff  = rem_s - {1'b0, dvs};
  assign ge    = rem_s >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= wide ? WIDE_STEPS : NARROW_STEPS;
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      dvs  <= divisor;
      quot <= wide ? dividend : {dividend[31:0], 22'd0};
    end else if (busy) begin
      rem  <= ge ? diff[31:0] : rem_s[31:0];
      quot <= {quot[52:0], ge};
    end
  end
endmodule

[design/sfpa_seq.sv]
// ----------------------------------------------------------------------------
// sfpa_seq: sequencer and datapath
// Steps one item through k squared, phase, the form factor terms, scale,
// the sine and cosine series and the saturating accumulators.
// ----------------------------------------------------------------------------
module sfpa_seq (
  input  logic            clk,
  input  logic            rst,
  input  sfpa_pkg::cfg_t  cfg,
  input  logic            start,
  input  sfpa_pkg::item_t itm_in,
  input  logic            out_free,
  output logic            idle,
  output logic            res_valid,
  output logic [31:0]     real_acc,
  output logic [31:0]     imag_acc,
  output logic            ovf
);
  import sfpa_pkg::*;

  localparam logic [5:0] S_IDLE  = 6'd0;
  localparam logic [5:0] S_WAIT  = 6'd1;
  localparam logic [5:0] S_K2A   = 6'd2;
  localparam logic [5:0] S_K2B   = 6'd3;
  localparam logic [5:0] S_K2C   = 6'd4;
  localparam logic [5:0] S_PH1   = 6'd5;
  localparam logic [5:0] S_PH2   = 6'd6;
  localparam logic [5:0] S_LOR   = 6'd7;
  localparam logic [5:0] S_LORD  = 6'd8;
  localparam logic [5:0] S_GAU0  = 6'd9;
  localparam logic [5:0] S_GAU1  = 6'd10;
  localparam logic [5:0] S_EXPM  = 6'd11;
  localparam logic [5:0] S_EXPD  = 6'd12;
  localparam logic [5:0] S_EXPS  = 6'd13;
  localparam logic [5:0] S_EXPN  = 6'd14;
  localparam logic [5:0] S_EXPR  = 6'd15;
  localparam logic [5:0] S_GMUL  = 6'd16;
  localparam logic [5:0] S_GADD  = 6'd17;
  localparam logic [5:0] S_TNEXT = 6'd18;
  localparam logic [5:0] S_SC1   = 6'd19;
  localparam logic [5:0] S_SC2   = 6'd20;
  localparam logic [5:0] S_SC3   = 6'd21;
  localparam logic [5:0] S_AM1   = 6'd22;
  localparam logic [5:0] S_AM2   = 6'd23;
  localparam logic [5:0] S_TH1   = 6'd24;
  localparam logic [5:0] S_TH2   = 6'd25;
  localparam logic [5:0] S_TRM   = 6'd26;
  localparam logic [5:0] S_TRD   = 6'd27;
  localparam logic [5:0] S_TRS   = 6'd28;
  localparam logic [5:0] S_QD    = 6'd29;
  localparam logic [5:0] S_RE1   = 6'd30;
  localparam logic [5:0] S_RE2   = 6'd31;
  localparam logic [5:0] S_IM2   = 6'd32;
  localparam logic [5:0] S_OUT   = 6'd33;

  logic [5:0]  state;
  logic [5:0]  ret;
  item_t       itm;
  logic [31:0] k2;
  logic [21:0] phase;
  logic [35:0] f;
  logic [IDX_W-1:0] idx;
  logic [4:0]  n;
  logic [23:0] frac;
  logic [31:0] term;
  logic signed [33:0] sum;
  logic [30:0] r;
  logic [3:0]  kcnt;
  logic [25:0] scale;
  logic [43:0] amp_lo;
  logic [37:0] amp;
  logic [30:0] theta;
  logic signed [33:0] sn;
  logic signed [33:0] cs;
  logic [30:0] cmag;
  logic [30:0] smag;
  logic        cneg;
  logic        sneg;

  logic        mul_start;
  logic [39:0] mul_a;
  logic [31:0] mul_b;
  logic        mul_done;
  logic [71:0] prod;
  logic        div_start;
  logic        div_wide;
  logic [53:0] div_dividend;
  logic [31:0] div_divisor;
  logic        div_done;
  logic [53:0] quot;

  logic [15:0] abs_x;
  logic [15:0] abs_y;
  logic [15:0] lor_a;
  logic [31:0] den;
  logic [37:0] e_val;
  logic [31:0] q32;
  logic signed [33:0] sum_upd;
  logic [32:0] re_res;
  logic [32:0] im_res;

  sfpa_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .prod(prod)
  );

  sfpa_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .wide(div_wide),
    .dividend(div_dividend), .divisor(div_divisor), .done(div_done), .quot(quot)
  );

  function automatic logic [35:0] f_add(input logic [35:0] fa, input logic [53:0] x);
    logic [54:0] s;
    s = 55'(fa) + 55'(x);
    return (s > 55'(F_MAX)) ? F_MAX : s[35:0];
  endfunction

  function automatic logic [30:0] clamp_unit(input logic signed [33:0] v);
    logic [30:0] o;
    if (v < 0) o = '0;
    else if (v > 34'(Q30_ONE)) o = Q30_ONE;
    else o = v[30:0];
    return o;
  endfunction

  // returns {clipped, new value}
  function automatic logic [32:0] sat_add(input logic [31:0] acc,
                                          input logic [37:0] p, input logic neg);
    logic signed [39:0] s;
    logic [32:0] o;
    s = neg ? ($signed({{8{acc[31]}}, acc}) - $signed({2'b00, p}))
            : ($signed({{8{acc[31]}}, acc}) + $signed({2'b00, p}));
    if (s > 40'sd2147483647) o = {1'b1, 32'h7FFF_FFFF};
    else if (s < -40'sd2147483648) o = {1'b1, 32'h8000_0000};
    else o = {1'b0, s[31:0]};
    return o;
  endfunction

  assign abs_x   = itm.freq_x[15] ? 16'(~itm.freq_x + 16'sd1) : 16'(itm.freq_x);
  assign abs_y   = itm.freq_y[15] ? 16'(~itm.freq_y + 16'sd1) : 16'(itm.freq_y);
  assign lor_a   = coef(cfg.lorentz_numerators, idx);
  assign den     = k2 + {2'b00, coef(cfg.lorentz_offsets, idx), 14'd0};
  assign e_val   = prod[47:10];
  assign q32     = quot[31:0];
  assign sum_upd = kcnt[0] ? (sum - $signed({2'b00, q32})) : (sum + $signed({2'b00, q32}));
  assign re_res  = sat_add(real_acc, prod[61:24], cneg);
  assign im_res  = sat_add(imag_acc, prod[61:24], sneg);

  assign idle      = (state == S_IDLE);
  assign res_valid = (state == S_OUT);

  always_comb begin
    mul_start    = 1'b0;
    mul_a        = '0;
    mul_b        = '0;
    div_start    = 1'b0;
    div_wide     = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    unique case (state)
      S_K2A: begin
        mul_start = 1'b1; mul_a = 40'(abs_x); mul_b = 32'(abs_x);
      end
      S_K2B: begin
        mul_start = 1'b1; mul_a = 40'(abs_y); mul_b = 32'(abs_y);
      end
      S_K2C: begin
        mul_start = 1'b1;
        mul_a = 40'({{2{itm.pos_x[19]}}, itm.pos_x});
        mul_b = 32'({{6{itm.freq_x[15]}}, itm.freq_x});
      end
      S_PH1: begin
        mul_start = 1'b1;
        mul_a = 40'({{2{itm.pos_y[19]}}, itm.pos_y});
        mul_b = 32'({{6{itm.freq_y[15]}}, itm.freq_y});
      end
      S_LOR: begin
        if (lor_a != 16'd0) begin
          div_start = 1'b1; div_wide = 1'b1;
          div_dividend = {lor_a, 38'd0}; div_divisor = den;
        end
      end
      S_GAU0: begin
        mul_start = 1'b1; mul_a = 40'(coef(cfg.gauss_rates, idx)); mul_b = k2;
      end
      S_EXPM: begin
        mul_start = 1'b1; mul_a = 40'(frac); mul_b = term;
      end
      S_EXPD: begin
        div_start = 1'b1; div_dividend = 54'(prod[55:24]); div_divisor = 32'(kcnt);
      end
      S_EXPN: begin
        if (n != 5'd0) begin
          mul_start = 1'b1; mul_a = 40'(r); mul_b = EXP_NEG_ONE;
        end
      end
      S_GMUL: begin
        mul_start = 1'b1; mul_a = 40'(coef(cfg.gauss_weights, idx)); mul_b = 32'(r);
      end
      S_SC1: begin
        mul_start = 1'b1; mul_a = 40'(cfg.mass_ratio); mul_b = 32'(cfg.wavelength);
      end
      S_SC2: begin
        mul_start = 1'b1; mul_a = 40'(cfg.inverse_area); mul_b = prod[31:0];
      end
      S_SC3: begin
        mul_start = 1'b1; mul_a = 40'(f[17:0]); mul_b = 32'(prod[55:30]);
      end
      S_AM1: begin
        mul_start = 1'b1; mul_a = 40'(f[35:18]); mul_b = 32'(scale);
      end
      S_TH1: begin
        mul_start = 1'b1; mul_a = 40'(phase[19:0]); mul_b = HALF_PI;
      end
      S_TRM: begin
        mul_start = 1'b1; mul_a = 40'(theta); mul_b = term;
      end
      S_TRD: begin
        div_start = 1'b1; div_dividend = 54'(prod[61:30]); div_divisor = 32'(kcnt);
      end
      S_RE1: begin
        mul_start = 1'b1; mul_a = 40'(amp); mul_b = 32'(cmag[30:6]);
      end
      S_RE2: begin
        mul_start = 1'b1; mul_a = 40'(amp); mul_b = 32'(smag[30:6]);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      ret      <= S_IDLE;
      kcnt     <= '0;
      real_acc <= '0;
      imag_acc <= '0;
      ovf      <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            itm <= itm_in;
            if (itm_in.clear_sum) begin
              real_acc <= '0;
              imag_acc <= '0;
              ovf      <= 1'b0;
            end
            state <= S_K2A;
          end
        end
        S_WAIT: begin
          if (mul_done || div_done) state <= ret;
        end
        S_K2A: begin
          ret <= S_K2B; state <= S_WAIT;
        end
        S_K2B: begin
          k2 <= prod[31:0];
          ret <= S_K2C; state <= S_WAIT;
        end
        S_K2C: begin
          k2 <= k2 + prod[31:0];
          ret <= S_PH1; state <= S_WAIT;
        end
        S_PH1: begin
          phase <= prod[21:0];
          ret <= S_PH2; state <= S_WAIT;
        end
        S_PH2: begin
          phase <= phase + prod[21:0];
          f     <= '0;
          idx   <= '0;
          state <= S_LOR;
        end
        S_LOR: begin
          // zero numerator adds nothing; the division is skipped
          if (lor_a != 16'd0) begin
            ret <= S_LORD; state <= S_WAIT;
          end else begin
            state <= S_GAU0;
          end
        end
        S_LORD: begin
          f <= f_add(f, quot);
          state <= S_GAU0;
        end
        S_GAU0: begin
          ret <= S_GAU1; state <= S_WAIT;
        end
        S_GAU1: begin
          if (|e_val[37:29]) begin
            state <= S_TNEXT;
          end else begin
            n     <= e_val[28:24];
            frac  <= e_val[23:0];
            term  <= 32'(Q30_ONE);
            sum   <= 34'(Q30_ONE);
            kcnt  <= 4'd1;
            state <= S_EXPM;
          end
        end
        S_EXPM: begin
          ret <= S_EXPD; state <= S_WAIT;
        end
        S_EXPD: begin
          ret <= S_EXPS; state <= S_WAIT;
        end
        S_EXPS: begin
          term <= q32;
          sum  <= sum_upd;
          if (kcnt == EXP_TERMS) begin
            r     <= clamp_unit(sum_upd);
            state <= S_EXPN;
          end else begin
            kcnt  <= kcnt + 4'd1;
            state <= S_EXPM;
          end
        end
        S_EXPN: begin
          if (n == 5'd0) begin
            state <= S_GMUL;
          end else begin
            ret <= S_EXPR; state <= S_WAIT;
          end
        end
        S_EXPR: begin
          r     <= prod[60:30];
          n     <= n - 5'd1;
          state <= S_EXPN;
        end
        S_GMUL: begin
          ret <= S_GADD; state <= S_WAIT;
        end
        S_GADD: begin
          f <= f_add(f, 54'(prod[46:16]));
          state <= S_TNEXT;
        end
        S_TNEXT: begin
          if (32'(idx) == TERM_COUNT - 1) begin
            state <= S_SC1;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_LOR;
          end
        end
        S_SC1: begin
          ret <= S_SC2; state <= S_WAIT;
        end
        S_SC2: begin
          ret <= S_SC3; state <= S_WAIT;
        end
        S_SC3: begin
          scale <= prod[55:30];
          ret <= S_AM1; state <= S_WAIT;
        end
        S_AM1: begin
          amp_lo <= prod[43:0];
          ret <= S_AM2; state <= S_WAIT;
        end
        S_AM2: begin
          amp   <= 38'((64'(amp_lo) + {2'b00, prod[43:0], 18'd0}) >> 24);
          state <= S_TH1;
        end
        S_TH1: begin
          ret <= S_TH2; state <= S_WAIT;
        end
        S_TH2: begin
          theta <= prod[50:20];
          term  <= 32'(Q30_ONE);
          sn    <= '0;
          cs    <= 34'(Q30_ONE);
          kcnt  <= 4'd1;
          state <= S_TRM;
        end
        S_TRM: begin
          ret <= S_TRD; state <= S_WAIT;
        end
        S_TRD: begin
          ret <= S_TRS; state <= S_WAIT;
        end
        S_TRS: begin
          term <= q32;
          case (kcnt[1:0])
            2'd1:    sn <= sn + $signed({2'b00, q32});
            2'd2:    cs <= cs - $signed({2'b00, q32});
            2'd3:    sn <= sn - $signed({2'b00, q32});
            default: cs <= cs + $signed({2'b00, q32});
          endcase
          if (kcnt == TRIG_TERMS) begin
            state <= S_QD;
          end else begin
            kcnt  <= kcnt + 4'd1;
            state <= S_TRM;
          end
        end
        S_QD: begin
          // quadrant rotation of the first-quadrant pair
          case (phase[21:20])
            2'd0: begin
              cmag <= clamp_unit(cs); cneg <= 1'b0;
              smag <= clamp_unit(sn); sneg <= 1'b0;
            end
            2'd1: begin
              cmag <= clamp_unit(sn); cneg <= 1'b1;
              smag <= clamp_unit(cs); sneg <= 1'b0;
            end
            2'd2: begin
              cmag <= clamp_unit(cs); cneg <= 1'b1;
              smag <= clamp_unit(sn); sneg <= 1'b1;
            end
            default: begin
              cmag <= clamp_unit(sn); cneg <= 1'b0;
              smag <= clamp_unit(cs); sneg <= 1'b1;
            end
          endcase
          state <= S_RE1;
        end
        S_RE1: begin
          ret <= S_RE2; state <= S_WAIT;
        end
        S_RE2: begin
          real_acc <= re_res[31:0];
          if (re_res[32]) ovf <= 1'b1;
          ret <= S_IM2; state <= S_WAIT;
        end
        S_IM2: begin
          imag_acc <= im_res[31:0];
          if (im_res[32]) ovf <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_one_unit: assert property (@(posedge clk) disable iff (rst)
    !(mul_start && div_start))
    else $error("multiplier and divider started together");

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> state == S_IDLE)
    else $error("item accepted while busy");

  a_ovf_sticky: assert property (@(posedge clk) disable iff (rst)
    (ovf && !(start && itm_in.clear_sum)) |=> ovf)
    else $error("saturation flag dropped without a clear");

  a_kcnt_range: assert property (@(posedge clk) disable iff (rst)
    kcnt <= TRIG_TERMS)
    else $error("series counter out of range");
endmodule

[design/scattering_factor_phase_accumulator_unit.sv]
// ----------------------------------------------------------------------------
// scattering_factor_phase_accumulator_unit: structure factor accumulator
// Adds one atom's scattering term times its phase factor into running
// real and imaginary sums.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one atom per beat: frequency point and position in
//   tdata, the clear flag in tuser. m_axis returns the running real and
//   imaginary sums after that atom, with the sticky saturation flag in
//   tuser. One result beat per input beat, in order.
//   cfg writes one coefficient register per beat (index, data); cfg_ready
//   is always high, writes belong between items.
// Sequencing:
//   per term the radix-2 divider runs one 54-step division when its
//   numerator is nonzero and twelve 32-step series divisions unless the
//   exponent reaches 32; per item it runs fourteen more for sine and
//   cosine, each division next to a multiply; each whole unit of the
//   exponent adds one multiply. s_axis_tready is high only while the
//   sequencer is idle, so an item is taken only once the last is done.
// Reset clears the accumulators, the flag and the registers to defaults.
// A stalled m_axis holds its beat; the finished item waits for the slot,
// and the next item is taken as soon as that beat is in the output register.
// ----------------------------------------------------------------------------
module scattering_factor_phase_accumulator_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // freq_x, freq_y, pos_x, pos_y
  input  logic [0:0]  s_axis_tuser,   // clear_sum
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // real_sum, imag_sum
  output logic [0:0]  m_axis_tuser,   // saturated
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data
);
  import sfpa_pkg::*;

  cfg_t        cfg;
  item_t       itm;
  logic        idle;
  logic        res_valid;
  logic        out_free;
  logic [31:0] real_acc;
  logic [31:0] imag_acc;
  logic        ovf;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = idle;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  assign itm.freq_x    = s_axis_tdata[15:0];
  assign itm.freq_y    = s_axis_tdata[31:16];
  assign itm.pos_x     = s_axis_tdata[51:32];
  assign itm.pos_y     = s_axis_tdata[71:52];
  assign itm.clear_sum = s_axis_tuser[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wavelength         <= 16'd0;
      cfg.mass_ratio         <= 16'd16384;
      cfg.inverse_area       <= 24'd0;
      cfg.lorentz_numerators <= 48'd0;
      cfg.lorentz_offsets    <= 48'd0;
      cfg.gauss_weights      <= 48'd0;
      cfg.gauss_rates        <= 48'd0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_WAVELENGTH:   cfg.wavelength         <= cfg_data[15:0];
        CFG_MASS_RATIO:   cfg.mass_ratio         <= cfg_data[15:0];
        CFG_INVERSE_AREA: cfg.inverse_area       <= cfg_data[23:0];
        CFG_LORENTZ_NUM:  cfg.lorentz_numerators <= cfg_data;
        CFG_LORENTZ_OFS:  cfg.lorentz_offsets    <= cfg_data;
        CFG_GAUSS_WEIGHT: cfg.gauss_weights      <= cfg_data;
        CFG_GAUSS_RATE:   cfg.gauss_rates        <= cfg_data;
        default: ;
      endcase
    end
  end

  sfpa_seq u_seq (
    .clk(clk), .rst(rst), .cfg(cfg),
    .start(s_axis_tvalid && s_axis_tready), .itm_in(itm),
    .out_free(out_free), .idle(idle), .res_valid(res_valid),
    .real_acc(real_acc), .imag_acc(imag_acc), .ovf(ovf)
  );

  // output beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_valid && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && out_free) begin
      m_axis_tdata <= {imag_acc, real_acc};
      m_axis_tuser <= ovf;
    end
  end
endmodule

[sim/scattering_factor_phase_accumulator_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scattering_factor_phase_accumulator_unit_tb: structure factor accumulator test
// Drives atom beats under several coefficient sets, predicts the running
// real and imaginary sums in fixed point and checks every result beat.
// ----------------------------------------------------------------------------
import sfpa_pkg::*;

class sum_scoreboard;
  logic [15:0] wl, mr;
  logic [23:0] ia;
  logic [47:0] lnum, lofs, gw, gr;
  longint re_acc, im_acc;
  bit ovf;
  logic [64:0] pending[$];
  int errors;

  function new();
    wl = 0; mr = 16'd16384; ia = 0; lnum = 0; lofs = 0; gw = 0; gr = 0;
    re_acc = 0; im_acc = 0; ovf = 0; errors = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [47:0] v);
    case (idx)
      CFG_WAVELENGTH:   wl = v[15:0];
      CFG_MASS_RATIO:   mr = v[15:0];
      CFG_INVERSE_AREA: ia = v[23:0];
      CFG_LORENTZ_NUM:  lnum = v;
      CFG_LORENTZ_OFS:  lofs = v;
      CFG_GAUSS_WEIGHT: gw = v;
      CFG_GAUSS_RATE:   gr = v;
      default: ;
    endcase
  endfunction

  function logic [63:0] decay(logic [63:0] e);
    logic [63:0] frac, t, r, n;
    longint s;
    if (e >= (64'd32 << 24)) return 0;
    n = e >> 24; frac = e & 64'hFFFFFF; t = 64'd1 << 30; s = 64'd1 << 30;
    for (int k = 1; k <= 12; k++) begin
      t = ((t * frac) >> 24) / k;
      if (k & 1) s -= longint'(t); else s += longint'(t);
    end
    if (s < 0) s = 0;
    if (s > (64'd1 << 30)) s = 64'd1 << 30;
    r = s;
    for (int j = 0; j < n; j++) r = (r * 64'd395007542) >> 30;
    return r;
  endfunction

  function logic [63:0] unit_clip(longint v);
    if (v < 0) return 0;
    if (v > (64'd1 << 30)) return 64'd1 << 30;
    return v;
  endfunction

  function longint clip_add(longint a, longint b);
    longint s;
    s = a + b;
    if (s > 64'sd2147483647) begin ovf = 1; return 64'sd2147483647; end
    if (s < -64'sd2147483648) begin ovf = 1; return -64'sd2147483648; end
    return s;
  endfunction

  function void note_atom(item_t it);
    longint kx, ky, px, py, sn, cs, rc, rs;
    logic [63:0] k2, f, sc, amp, ph, r, th, t, sv, cv, cm, sm, a, den, c, e;
    bit cn, sg;
    kx = it.freq_x; ky = it.freq_y; px = it.pos_x; py = it.pos_y;
    k2 = kx * kx + ky * ky;
    if (it.clear_sum) begin re_acc = 0; im_acc = 0; ovf = 0; end
    f = 0;
    for (int i = 0; i < 3; i++) begin
      a = lnum[16*i +: 16];
      den = k2 + (64'(lofs[16*i +: 16]) << 14);
      c = gw[16*i +: 16];
      e = (64'(gr[16*i +: 16]) * k2) >> 10;
      if (den == 0) f += (a != 0) ? (64'd1 << 54) : 0;
      else f += (a << 38) / den;
      f += (c * decay(e)) >> 16;
    end
    if (f > ((64'd1 << 36) - 1)) f = (64'd1 << 36) - 1;
    sc = ((64'(wl) * mr) * ia) >> 30;
    amp = (f * sc) >> 24;
    ph = 64'(kx * px + ky * py) & 64'h3FFFFF;
    r = ph & 64'hFFFFF;
    th = (r * 64'd1686629713) >> 20;
    t = 64'd1 << 30; cs = 64'd1 << 30; sn = 0;
    for (int k = 1; k <= 14; k++) begin
      t = ((t * th) >> 30) / k;
      case (k & 3)
        1: sn += longint'(t);
        2: cs -= longint'(t);
        3: sn -= longint'(t);
        default: cs += longint'(t);
      endcase
    end
    sv = unit_clip(sn); cv = unit_clip(cs);
    case (ph[21:20])
      2'd0: begin cm = cv; cn = 0; sm = sv; sg = 0; end
      2'd1: begin cm = sv; cn = 1; sm = cv; sg = 0; end
      2'd2: begin cm = cv; cn = 1; sm = sv; sg = 1; end
      default: begin cm = sv; cn = 0; sm = cv; sg = 1; end
    endcase
    rc = longint'((amp * (cm >> 6)) >> 24);
    rs = longint'((amp * (sm >> 6)) >> 24);
    re_acc = clip_add(re_acc, cn ? -rc : rc);
    im_acc = clip_add(im_acc, sg ? -rs : rs);
    pending.push_back({ovf, im_acc[31:0], re_acc[31:0]});
  endfunction

  function void check_sum(logic [63:0] d, logic u);
    logic [64:0] x;
    if (pending.size() == 0) begin
      $error("result beat with nothing expected"); errors++; return;
    end
    x = pending.pop_front();
    if (d[31:0] !== x[31:0]) begin
      $error("real_sum expected %h actual %h", x[31:0], d[31:0]); errors++;
    end
    if (d[63:32] !== x[63:32]) begin
      $error("imag_sum expected %h actual %h", x[63:32], d[63:32]); errors++;
    end
    if (u !== x[64]) begin
      $error("saturated expected %b actual %b", x[64], u); errors++;
    end
  endfunction
endclass

module scattering_factor_phase_accumulator_unit_tb;
  logic clk = 0, rst = 1;
  logic s_axis_tvalid = 0, s_axis_tready;
  logic [71:0] s_axis_tdata = 0;
  logic [0:0] s_axis_tuser = 0;
  logic m_axis_tvalid, m_axis_tready = 0;
  logic [63:0] m_axis_tdata;
  logic [0:0] m_axis_tuser;
  logic cfg_valid = 0, cfg_ready;
  logic [2:0] cfg_index = 0;
  logic [47:0] cfg_data = 0;
  sum_scoreboard sb = new();

  scattering_factor_phase_accumulator_unit i_dut (.*);

  always begin #6 clk = 1; #6 clk = 0; end

  function int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
  endfunction

  // random stall on the result side
  int stall_mode = 0;
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_sum(m_axis_tdata, m_axis_tuser[0]);
  end
  always @(negedge clk) begin
    if (stall_mode == 0) m_axis_tready <= 1;
    else m_axis_tready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 40) == 0);
  end

  task automatic write_reg(logic [2:0] idx, logic [47:0] v);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, v);
    @(negedge clk);
    cfg_valid <= 0;
    @(negedge clk);
  endtask

  task automatic send_atom(item_t it, bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    repeat (g) @(negedge clk);
    s_axis_tvalid <= 1;
    s_axis_tdata <= {it.pos_y, it.pos_x, it.freq_y, it.freq_x};
    s_axis_tuser <= it.clear_sum;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_atom(it);
    @(negedge clk);
    s_axis_tvalid <= 0;
    @(negedge clk);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  function logic [47:0] rand48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  function item_t rand_atom();
    item_t it;
    int m;
    m = $urandom_range(0, 3);
    it.freq_x = (m == 0) ? 16'($urandom) : 16'($signed($urandom_range(0, 4095)) - 2048);
    it.freq_y = (m == 0) ? 16'($urandom) : 16'($signed($urandom_range(0, 4095)) - 2048);
    it.pos_x = 20'($urandom);
    it.pos_y = 20'($urandom);
    it.clear_sum = ($urandom_range(0, 15) == 0);
    return it;
  endfunction

  task automatic random_setting(int kind);
    case (kind)
      0: begin
        write_reg(CFG_WAVELENGTH, 48'hFFFF); write_reg(CFG_MASS_RATIO, 48'hFFFF);
        write_reg(CFG_INVERSE_AREA, 48'hFFFFFF);
        write_reg(CFG_LORENTZ_NUM, {48{1'b1}}); write_reg(CFG_LORENTZ_OFS, {48{1'b1}});
        write_reg(CFG_GAUSS_WEIGHT, {48{1'b1}}); write_reg(CFG_GAUSS_RATE, {48{1'b1}});
      end
      1: begin
        write_reg(CFG_WAVELENGTH, 48'd0); write_reg(CFG_MASS_RATIO, 48'd0);
        write_reg(CFG_INVERSE_AREA, 48'd0);
        write_reg(CFG_LORENTZ_NUM, 48'd0); write_reg(CFG_LORENTZ_OFS, 48'd0);
        write_reg(CFG_GAUSS_WEIGHT, 48'd0); write_reg(CFG_GAUSS_RATE, 48'd0);
      end
      default: begin
        write_reg(CFG_WAVELENGTH, 48'($urandom_range(0, 65535)));
        write_reg(CFG_MASS_RATIO, 48'($urandom_range(0, 65535)));
        write_reg(CFG_INVERSE_AREA, 48'($urandom));
        write_reg(CFG_LORENTZ_NUM, rand48()); write_reg(CFG_LORENTZ_OFS, rand48());
        write_reg(CFG_GAUSS_WEIGHT, rand48()); write_reg(CFG_GAUSS_RATE, rand48());
      end
    endcase
    // out-of-range index is ignored
    write_reg(3'd7, rand48());
  endtask

  initial begin
    item_t it;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // defaults first: zero scale
    it = '{16'sh7FFF, -16'sh8000, 20'sh7FFFF, -20'sh80000, 1'b1};
    send_atom(it, 0);
    drain();
    // large scale, zero offsets so a zero frequency hits the zero denominator
    write_reg(CFG_WAVELENGTH, 48'hFFFF); write_reg(CFG_MASS_RATIO, 48'hFFFF);
    write_reg(CFG_INVERSE_AREA, 48'hFFFFFF);
    write_reg(CFG_LORENTZ_NUM, 48'h0001_0000_FFFF); write_reg(CFG_LORENTZ_OFS, 48'h0);
    write_reg(CFG_GAUSS_WEIGHT, {48{1'b1}}); write_reg(CFG_GAUSS_RATE, 48'hFFFF_0010_0000);
    stall_mode = 1;
    send_atom('{16'sd0, 16'sd0, 20'sd0, 20'sd0, 1'b1}, 1);
    for (int q = 0; q < 4; q++)
      send_atom('{16'sd1, 16'sd0, 20'(q << 20) + 20'sd12345, 20'sd0, 1'b0}, 1);
    send_atom('{16'sh7FFF, 16'sh7FFF, 20'sh7FFFF, 20'sh7FFFF, 1'b0}, 1);
    send_atom('{-16'sh8000, -16'sh8000, -20'sh80000, -20'sh80000, 1'b0}, 1);
    for (int j = 0; j < 10; j++) send_atom('{16'sd3, 16'sd0, 20'sd0, 20'sd0, 1'b0}, 0);
    send_atom('{16'sd3, 16'sd0, 20'sd0, 20'sd0, 1'b1}, 0);
    drain();
    for (int p = 0; p < 8; p++) begin
      random_setting(p % 3);
      stall_mode = $urandom_range(0, 2);
      for (int n = 0; n < 80; n++) send_atom(rand_atom(), stall_mode != 0);
      drain();
    end
    if (sb.errors == 0 && sb.pending.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #150ms;
    $display("TEST FAILED");
    $finish;
  end
endmodule

[sim.f]
design/sfpa_pkg.sv
design/sfpa_mul.sv
design/sfpa_div.sv
design/sfpa_seq.sv
design/scattering_factor_phase_accumulator_unit.sv
sim/scattering_factor_phase_accumulator_unit_tb.sv
